// ===== hw/rtl/skt_pkg.sv =====
// shared types and status codes for the sorted key table
// no dependencies; imported by skt_key_ram, sorted_key_table and tb_top
`default_nettype none

package skt_pkg;

    // fixed field widths of the request and response
    localparam int unsigned KEY_BITS   = 32;
    localparam int unsigned POS_BITS   = 7;
    localparam int unsigned COUNT_BITS = 7;

    // operation codes
    typedef enum logic [0:0] {
        FUNC_ADD    = 1'b0,
        FUNC_REMOVE = 1'b1
    } func_t;

    // response status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_MISSING = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    typedef struct packed {
        logic [0:0]          func;
        logic [KEY_BITS-1:0] key;
    } req_t;

    typedef struct packed {
        logic [1:0]            status;
        logic [POS_BITS-1:0]   position;
        logic [COUNT_BITS-1:0] count;
    } rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sorted_key_table.sv =====
// top level of the sorted key table: sequencer, search and shift control
// depends on skt_pkg and skt_key_ram
`default_nettype none

// Holds up to DEPTH keys in ascending order in a single-port-read,
// single-port-write RAM with registered read data. Each request adds a
// key in order (duplicates allowed) or removes one equal key, and yields
// exactly one response with status, position and the new count. One
// request is handled at a time: idle, a check of the last and first entry
// (not on an empty table), one RAM read per binary search probe where the
// checks do not settle it, plan, a move of the count - position later
// entries one place through the RAM read/write ports on an add, or of the
// count - position - 1 later entries on a remove, and final. A rejected
// add (full) or remove (not found) skips the move. The RAM read port sets
// the rate: every probe and every moved entry costs one read. req_stall is
// high while a request is in work; a finished response waits in an output
// register while the next request is accepted.
module sorted_key_table #(
    parameter int unsigned DEPTH     = 64,
    parameter int unsigned KEY_WIDTH = 32
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire skt_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output skt_pkg::rsp_t      rsp
);
    import skt_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_LAST  = 7'b0000010,
        S_FIRST = 7'b0000100,
        S_PROBE = 7'b0001000,
        S_PLAN  = 7'b0010000,
        S_MOVE  = 7'b0100000,
        S_FINAL = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [CW-1:0]        count_reg, count_next;
    logic                 func_reg, func_next;
    logic [KEY_WIDTH-1:0] key_reg, key_next;
    logic [AW-1:0]        lo_reg, lo_next;
    logic [AW-1:0]        hi_reg, hi_next;
    logic [AW-1:0]        mid_reg, mid_next;
    logic [CW-1:0]        pos_reg, pos_next;
    logic                 hit_reg, hit_next;
    logic [1:0]           status_reg, status_next;
    logic                 up_reg, up_next;
    logic [AW-1:0]        src_reg, src_next;
    logic [CW-1:0]        left_reg, left_next;
    logic                 pend_reg, pend_next;
    logic [AW-1:0]        pend_addr_reg, pend_addr_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    rsp_t                 rsp_reg, rsp_next;

    // ram ports
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [KEY_WIDTH-1:0] wr_data;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic [KEY_WIDTH-1:0] rd_data;

    // search helpers
    logic                 probe_gt;
    logic                 probe_lt;
    logic [AW-1:0]        dn_hi;
    logic [AW-1:0]        up_lo;
    logic [AW-1:0]        first_hi;
    logic                 rsp_free;
    logic                 add_ok;

    skt_key_ram #(
        .DEPTH     (DEPTH),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign probe_gt = (rd_data > key_reg);
    assign probe_lt = (rd_data < key_reg);
    assign dn_hi    = mid_reg - AW'(1);
    assign up_lo    = mid_reg + AW'(1);
    assign first_hi = AW'(count_reg - CW'(1));
    assign rsp_free = !rsp_valid_reg || !rsp_stall;
    assign add_ok   = (func_reg == FUNC_ADD) && (status_reg == ST_OK);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        func_next      = func_reg;
        key_next       = key_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        pos_next       = pos_reg;
        hit_next       = hit_reg;
        status_next    = status_reg;
        up_next        = up_reg;
        src_next       = src_reg;
        left_next      = left_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rd_en          = 1'b0;
        rd_addr        = first_hi;
        wr_en          = 1'b0;
        wr_addr        = pend_addr_reg;
        wr_data        = rd_data;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    func_next = req.func;
                    key_next  = KEY_WIDTH'(req.key);
                    pos_next  = '0;
                    hit_next  = 1'b0;
                    if (count_reg == '0)
                    begin
                        state_next = S_PLAN;
                    end
                    else
                    begin
                        // fetch the last entry
                        rd_en      = 1'b1;
                        rd_addr    = first_hi;
                        state_next = S_LAST;
                    end
                end
            end

            S_LAST:
            begin
                if (probe_lt)
                begin
                    // key above the last entry
                    pos_next   = count_reg;
                    state_next = S_PLAN;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = '0;
                    state_next = S_FIRST;
                end
            end

            S_FIRST:
            begin
                if (probe_gt)
                begin
                    // key below the first entry
                    pos_next   = '0;
                    state_next = S_PLAN;
                end
                else
                begin
                    lo_next    = '0;
                    hi_next    = first_hi;
                    mid_next   = first_hi >> 1;
                    rd_en      = 1'b1;
                    rd_addr    = first_hi >> 1;
                    state_next = S_PROBE;
                end
            end

            S_PROBE:
            begin
                if (probe_gt)
                begin
                    if (mid_reg == lo_reg)
                    begin
                        pos_next   = CW'(mid_reg);
                        state_next = S_PLAN;
                    end
                    else
                    begin
                        hi_next  = dn_hi;
                        mid_next = lo_reg + ((dn_hi - lo_reg) >> 1);
                        rd_en    = 1'b1;
                        rd_addr  = lo_reg + ((dn_hi - lo_reg) >> 1);
                    end
                end
                else if (probe_lt)
                begin
                    if (mid_reg == hi_reg)
                    begin
                        pos_next   = CW'(mid_reg) + CW'(1);
                        state_next = S_PLAN;
                    end
                    else
                    begin
                        lo_next  = up_lo;
                        mid_next = up_lo + ((hi_reg - up_lo) >> 1);
                        rd_en    = 1'b1;
                        rd_addr  = up_lo + ((hi_reg - up_lo) >> 1);
                    end
                end
                else
                begin
                    // equal entry found
                    hit_next   = 1'b1;
                    pos_next   = CW'(mid_reg);
                    state_next = S_PLAN;
                end
            end

            S_PLAN:
            begin
                pend_next = 1'b0;
                if (func_reg == FUNC_ADD)
                begin
                    up_next   = 1'b1;
                    src_next  = first_hi;
                    left_next = count_reg - pos_reg;
                    if (count_reg == CW'(DEPTH))
                    begin
                        status_next = ST_FULL;
                        state_next  = S_FINAL;
                    end
                    else
                    begin
                        status_next = ST_OK;
                        state_next  = S_MOVE;
                    end
                end
                else
                begin
                    up_next   = 1'b0;
                    src_next  = AW'(pos_reg) + AW'(1);
                    left_next = count_reg - pos_reg - CW'(1);
                    if (!hit_reg)
                    begin
                        status_next = ST_MISSING;
                        state_next  = S_FINAL;
                    end
                    else
                    begin
                        status_next = ST_OK;
                        state_next  = S_MOVE;
                    end
                end
            end

            S_MOVE:
            begin
                // write back the entry read in the previous cycle
                wr_en   = pend_reg;
                wr_addr = pend_addr_reg;
                wr_data = rd_data;
                if (left_reg != '0)
                begin
                    rd_en          = 1'b1;
                    rd_addr        = src_reg;
                    pend_next      = 1'b1;
                    pend_addr_next = up_reg ? (src_reg + AW'(1)) : (src_reg - AW'(1));
                    src_next       = up_reg ? (src_reg - AW'(1)) : (src_reg + AW'(1));
                    left_next      = left_reg - CW'(1);
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = S_FINAL;
                end
            end

            S_FINAL:
            begin
                if (rsp_free)
                begin
                    // insert the new key on an accepted add, and report
                    wr_en   = add_ok;
                    wr_addr = AW'(pos_reg);
                    wr_data = key_reg;
                    if (status_reg == ST_OK)
                    begin
                        count_next = (func_reg == FUNC_ADD) ? (count_reg + CW'(1))
                                                            : (count_reg - CW'(1));
                    end
                    rsp_next.status   = status_reg;
                    rsp_next.position = POS_BITS'(pos_reg);
                    rsp_next.count    = COUNT_BITS'((status_reg == ST_OK)
                                        ? ((func_reg == FUNC_ADD) ? (count_reg + CW'(1))
                                                                  : (count_reg - CW'(1)))
                                        : count_reg);
                    rsp_valid_next    = 1'b1;
                    state_next        = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // working and payload registers
    always_ff @(posedge clk)
    begin
        func_reg      <= func_next;
        key_reg       <= key_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        mid_reg       <= mid_next;
        pos_reg       <= pos_next;
        hit_reg       <= hit_next;
        status_reg    <= status_next;
        up_reg        <= up_next;
        src_reg       <= src_next;
        left_reg      <= left_next;
        pend_addr_reg <= pend_addr_next;
        rsp_reg       <= rsp_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/skt_key_ram.sv =====
// key storage: one write port, one read port, registered read data
// depends on skt_pkg only for house consistency of types
`default_nettype none

module skt_key_ram #(
    parameter int unsigned DEPTH     = 64,
    parameter int unsigned KEY_WIDTH = 32
) (
    input  wire logic                      clk,
    input  wire logic                      wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]  wr_addr,
    input  wire logic [KEY_WIDTH-1:0]      wr_data,
    input  wire logic                      rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]  rd_addr,
    output logic      [KEY_WIDTH-1:0]      rd_data
);
    import skt_pkg::*;

    logic [KEY_WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered read data
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// testbench for sorted_key_table: a directed request table, then random add/remove traffic
// depends on skt_pkg and the sorted_key_table RTL; responses are checked against a local table model

module tb_top;
    import skt_pkg::*;

    localparam int unsigned TABLE_DEPTH     = 64;
    localparam int unsigned RANDOM_REQUESTS = 530;
    localparam int unsigned SETTLE_CYCLES   = 150;

    // one row of the directed table; typed rows carry a hand-written response
    typedef struct packed {
        func_t                 op;
        logic [KEY_BITS-1:0]   key;
        logic                  typed;
        status_t               st;
        logic [POS_BITS-1:0]   pos;
        logic [COUNT_BITS-1:0] cnt;
    } plan_row_t;

    localparam int PLAN_LEN = 21;
    localparam plan_row_t PLAN [PLAN_LEN] = '{
        // remove from an empty table
        '{FUNC_REMOVE, 32'h0000_0005, 1'b1, ST_MISSING, 7'd0, 7'd0},
        // smallest and largest keys, then duplicates of both
        '{FUNC_ADD,    32'h0000_0000, 1'b1, ST_OK,      7'd0, 7'd1},
        '{FUNC_ADD,    32'hffff_ffff, 1'b1, ST_OK,      7'd1, 7'd2},
        '{FUNC_ADD,    32'h0000_0000, 1'b1, ST_OK,      7'd0, 7'd3},
        '{FUNC_ADD,    32'hffff_ffff, 1'b0, ST_OK,      7'd0, 7'd0},
        // sign-bit boundary and alternating bit patterns
        '{FUNC_ADD,    32'h8000_0000, 1'b0, ST_OK,      7'd0, 7'd0},
        '{FUNC_ADD,    32'h7fff_ffff, 1'b0, ST_OK,      7'd0, 7'd0},
        '{FUNC_ADD,    32'h5555_5555, 1'b0, ST_OK,      7'd0, 7'd0},
        '{FUNC_ADD,    32'haaaa_aaaa, 1'b0, ST_OK,      7'd0, 7'd0},
        '{FUNC_ADD,    32'h0000_0001, 1'b0, ST_OK,      7'd0, 7'd0},
        '{FUNC_ADD,    32'hffff_fffe, 1'b0, ST_OK,      7'd0, 7'd0},
        // absent key in the middle
        '{FUNC_REMOVE, 32'h1234_5678, 1'b0, ST_OK,      7'd0, 7'd0},
        // remove both zeros, then zero again below the first entry
        '{FUNC_REMOVE, 32'h0000_0000, 1'b0, ST_OK,      7'd0, 7'd0},
        '{FUNC_REMOVE, 32'h0000_0000, 1'b0, ST_OK,      7'd0, 7'd0},
        '{FUNC_REMOVE, 32'h0000_0000, 1'b0, ST_OK,      7'd0, 7'd0},
        // remove both top keys, then the top key again above the last entry
        '{FUNC_REMOVE, 32'hffff_ffff, 1'b0, ST_OK,      7'd0, 7'd0},
        '{FUNC_REMOVE, 32'hffff_ffff, 1'b0, ST_OK,      7'd0, 7'd0},
        '{FUNC_REMOVE, 32'hffff_ffff, 1'b0, ST_OK,      7'd0, 7'd0},
        '{FUNC_REMOVE, 32'h5555_5555, 1'b0, ST_OK,      7'd0, 7'd0},
        '{FUNC_REMOVE, 32'haaaa_aaaa, 1'b0, ST_OK,      7'd0, 7'd0},
        '{FUNC_ADD,    32'h5555_5555, 1'b0, ST_OK,      7'd0, 7'd0}
    };

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    req_t req       = '0;
    logic rsp_stall = 1'b0;
    logic req_stall;
    logic rsp_valid;
    rsp_t rsp;

    // local copy of the sorted table
    logic [KEY_BITS-1:0] held_keys [TABLE_DEPTH];
    int                  held_count = 0;
    rsp_t                pending_rsp [$];
    int                  fail_count = 0;
    bit                  steady     = 1'b0;

    sorted_key_table DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #1 clk = ~clk;

    // overall time limit
    initial
    begin
        #1_000_000;
        $display("sorted_key_table test failed");
        $finish;
    end

    // binary search over the held keys; hit is set on an equal probe
    function automatic int search_pos(input logic [KEY_BITS-1:0] k, output bit hit);
        int lo;
        int hi;
        int mid;
        hit = 1'b0;
        mid = 0;
        if (held_count == 0)
            return 0;
        if (k > held_keys[held_count-1])
            return held_count;
        if (k < held_keys[0])
            return 0;
        lo = 0;
        hi = held_count - 1;
        while (lo <= hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (held_keys[mid] > k)
            begin
                hi = mid - 1;
                if (hi < lo)
                    return mid;
            end
            else if (held_keys[mid] < k)
            begin
                lo = mid + 1;
                if (lo > hi)
                    return mid + 1;
            end
            else
            begin
                hit = 1'b1;
                return mid;
            end
        end
        return mid;
    endfunction

    // apply one request to the local table and return the response it gives
    function automatic rsp_t apply_request(input req_t r);
        rsp_t res;
        bit   hit;
        int   pos;
        pos = search_pos(r.key, hit);
        res.status = ST_OK;
        if (func_t'(r.func) == FUNC_ADD)
        begin
            if (held_count >= TABLE_DEPTH)
                res.status = ST_FULL;
            else
            begin
                for (int i = held_count; i > pos; i--)
                    held_keys[i] = held_keys[i-1];
                held_keys[pos] = r.key;
                held_count++;
            end
        end
        else if (!hit)
            res.status = ST_MISSING;
        else
        begin
            for (int i = pos; i + 1 < held_count; i++)
                held_keys[i] = held_keys[i+1];
            held_count--;
        end
        res.position = pos[POS_BITS-1:0];
        res.count    = held_count[COUNT_BITS-1:0];
        return res;
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int idle_length();
        int roll;
        if (steady)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // key choice: held keys for hits, a small pool for duplicates, extremes, full range
    function automatic logic [KEY_BITS-1:0] pick_key(input bit prefer_held);
        int roll;
        roll = $urandom_range(0, 9);
        if (prefer_held && held_count > 0 && roll < 8)
            return held_keys[$urandom_range(0, held_count - 1)];
        roll = $urandom_range(0, 9);
        if (roll < 4)
            return KEY_BITS'($urandom_range(0, 15));
        if (roll == 4)
        begin
            case ($urandom_range(0, 3))
                0: return '0;
                1: return '1;
                2: return 32'h7fff_ffff;
                default: return 32'h8000_0000;
            endcase
        end
        if (roll == 5 && held_count > 0)
            return held_keys[$urandom_range(0, held_count - 1)];
        return $urandom();
    endfunction

    // drive one request and record its expected response once accepted
    task automatic send_request(input req_t r, input bit typed, input rsp_t typed_rsp);
        rsp_t predicted;
        int   gap;
        gap = idle_length();
        @(negedge clk);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        do
            @(posedge clk);
        while (req_stall);
        predicted = apply_request(r);
        pending_rsp.push_back(typed ? typed_rsp : predicted);
    endtask

    // response side back-pressure
    initial
    begin
        int held;
        held = 0;
        forever
        begin
            @(negedge clk);
            if (held > 0)
            begin
                rsp_stall <= 1'b1;
                held--;
            end
            else
            begin
                rsp_stall <= 1'b0;
                held = idle_length();
            end
        end
    end

    // response check against the oldest expectation
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_rsp.size() == 0)
            begin
                $error("response with no request outstanding: %p", rsp);
                fail_count++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp.status);
                    fail_count++;
                end
                if (rsp.position !== want.position)
                begin
                    $error("position: expected %0d, got %0d", want.position, rsp.position);
                    fail_count++;
                end
                if (rsp.count !== want.count)
                begin
                    $error("count: expected %0d, got %0d", want.count, rsp.count);
                    fail_count++;
                end
            end
        end
    end

    // stimulus and end of run
    initial
    begin
        req_t  r;
        rsp_t  typed_rsp;
        bit    filling;
        func_t op;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table
        for (int i = 0; i < PLAN_LEN; i++)
        begin
            r.func             = PLAN[i].op;
            r.key              = PLAN[i].key;
            typed_rsp.status   = PLAN[i].st;
            typed_rsp.position = PLAN[i].pos;
            typed_rsp.count    = PLAN[i].cnt;
            send_request(r, PLAN[i].typed, typed_rsp);
        end

        // random fill and drain cycles, with rejected adds on a full table
        filling = 1'b1;
        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if ($urandom_range(0, 39) == 0)
                steady = !steady;
            if (filling && held_count == TABLE_DEPTH && $urandom_range(0, 3) == 0)
                filling = 1'b0;
            else if (!filling && held_count == 0 && $urandom_range(0, 2) != 0)
                filling = 1'b1;
            else if ($urandom_range(0, 99) == 0)
                filling = !filling;
            if ($urandom_range(0, 99) < 85)
                op = filling ? FUNC_ADD : FUNC_REMOVE;
            else
                op = filling ? FUNC_REMOVE : FUNC_ADD;
            r.func = op;
            r.key  = pick_key(op == FUNC_REMOVE);
            send_request(r, 1'b0, '0);
        end
        @(negedge clk);
        req_valid <= 1'b0;

        // wait out outstanding responses, then a settle window
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("sorted_key_table test passed");
        else
            $display("sorted_key_table test failed");
        $finish;
    end

endmodule
